// ===== hdl/pdc_pkg.sv =====
// Shared types and constants for the Playfair digraph cipher block.
package pdc_pkg;

   localparam logic [2:0] CMD_CLEAR    = 3'd0;
   localparam logic [2:0] CMD_KEY      = 3'd1;
   localparam logic [2:0] CMD_FINISH   = 3'd2;
   localparam logic [2:0] CMD_ENCIPHER = 3'd3;
   localparam logic [2:0] CMD_DECIPHER = 3'd4;

   localparam int unsigned SIDE    = 5;
   localparam int unsigned CELLS   = SIDE * SIDE;
   localparam int unsigned LETTERS = 26;

   localparam logic [4:0] LETTER_I = 5'd8;
   localparam logic [4:0] LETTER_J = 5'd9;
   localparam logic [4:0] LETTER_Z = 5'd25;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] key_char;
      logic [4:0] first_letter;
      logic [4:0] second_letter;
   } req_type;

   typedef struct packed {
      logic [4:0] result_first;
      logic [4:0] result_second;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic key_place;
      logic fin_clr_idx;
      logic fin_place;
      logic fin_done;
      logic pair_cap;
      logic cell_rd;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic square_ready;
      logic fin_last;
      logic rsp_busy;
   } ctl_sts_type;

endpackage

// ===== hdl/pdc_ctrl.sv =====
// Controller state machine sequencing key build, finish sweep and pair lookups.
module pdc_ctrl import pdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  req_command,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FIN  = 2'd1;
   localparam logic [1:0] S_CELL = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  CMD_KEY: begin
                     cmd.key_place = 1'b1;
                  end
                  CMD_FINISH: begin
                     if (!sts.square_ready) begin
                        cmd.fin_clr_idx = 1'b1;
                        state_in        = S_FIN;
                     end
                  end
                  CMD_ENCIPHER, CMD_DECIPHER: begin
                     cmd.pair_cap = 1'b1;
                     state_in     = sts.square_ready ? S_CELL : S_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIN: begin
            cmd.fin_place = 1'b1;
            if (sts.fin_last) begin
               cmd.fin_done = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CELL: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/pdc_datapath.sv =====
// Datapath: key square memories, letter tracking, pair transform and result register.
module pdc_datapath import pdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam logic [25:0] J_MASK = 26'd1 << LETTER_J;

   function automatic logic [4:0] fix_letter(input logic [4:0] raw);
      logic [4:0] v;
      v = (raw > LETTER_Z) ? LETTER_Z : raw;
      if (v == LETTER_J) begin
         v = LETTER_I;
      end
      return v;
   endfunction

   function automatic logic [2:0] step_coord(input logic [2:0] x, input logic back);
      logic [2:0] r;
      if (back) begin
         r = (x == 3'd0) ? 3'(SIDE - 1) : x - 3'd1;
      end else begin
         r = (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
      end
      return r;
   endfunction

   function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   logic [4:0]  cell_mem [0:CELLS-1];
   logic [5:0]  pos_mem [0:LETTERS-1];

   logic [25:0] used_ff;
   logic [4:0]  fill_cnt_ff;
   logic [2:0]  fill_row_ff;
   logic [2:0]  fill_col_ff;
   logic        ready_ff;
   logic [4:0]  fin_idx_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        dec_ff;
   logic        err_ff;
   logic [5:0]  pos_a_ff;
   logic [5:0]  pos_b_ff;
   logic [4:0]  cell_a_ff;
   logic [4:0]  cell_b_ff;
   rsp_type     rsp_ff;

   logic [7:0]  key_up;
   logic [7:0]  key_off;
   logic        key_is_letter;
   logic [4:0]  key_letter;
   logic [4:0]  place_letter;
   logic        place_en;
   logic [2:0]  ra, ca, rb, cb;
   logic [2:0]  ora, oca, orb, ocb;
   logic [4:0]  oa, ob;

   always_comb begin
      key_up = req_data.key_char;
      if (req_data.key_char >= 8'h61 && req_data.key_char <= 8'h7a) begin
         key_up = req_data.key_char - 8'h20;
      end
      key_is_letter = (key_up >= 8'h41) && (key_up <= 8'h5a);
      key_off       = key_up - 8'h41;
      key_letter    = (key_off[4:0] == LETTER_J) ? LETTER_I : key_off[4:0];
   end

   assign place_letter = cmd.fin_place ? fin_idx_ff : key_letter;
   assign place_en = (cmd.fin_place | (cmd.key_place & !ready_ff & key_is_letter))
                     & !used_ff[place_letter] & (fill_cnt_ff != 5'(CELLS));

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= J_MASK;
         fill_cnt_ff <= '0;
         fill_row_ff <= '0;
         fill_col_ff <= '0;
         ready_ff    <= 1'b0;
         fin_idx_ff  <= '0;
      end else begin
         if (cmd.clear) begin
            used_ff     <= J_MASK;
            fill_cnt_ff <= '0;
            fill_row_ff <= '0;
            fill_col_ff <= '0;
            ready_ff    <= 1'b0;
         end else begin
            if (place_en) begin
               used_ff     <= used_ff | (26'd1 << place_letter);
               fill_cnt_ff <= fill_cnt_ff + 5'd1;
               if (fill_col_ff == 3'(SIDE - 1)) begin
                  fill_col_ff <= '0;
                  fill_row_ff <= fill_row_ff + 3'd1;
               end else begin
                  fill_col_ff <= fill_col_ff + 3'd1;
               end
            end
            if (cmd.fin_done) begin
               ready_ff <= 1'b1;
            end
         end
         if (cmd.fin_clr_idx) begin
            fin_idx_ff <= '0;
         end else if (cmd.fin_place) begin
            fin_idx_ff <= fin_idx_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (place_en) begin
         cell_mem[fill_cnt_ff]  <= place_letter;
         pos_mem[place_letter] <= {fill_row_ff, fill_col_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pair_cap) begin
         pos_a_ff <= pos_mem[fix_letter(req_data.first_letter)];
         pos_b_ff <= pos_mem[fix_letter(req_data.second_letter)];
         dec_ff   <= (req_data.command == CMD_DECIPHER);
         err_ff   <= !ready_ff;
      end
   end

   always_comb begin
      ra  = pos_a_ff[5:3];
      ca  = pos_a_ff[2:0];
      rb  = pos_b_ff[5:3];
      cb  = pos_b_ff[2:0];
      ora = ra;
      orb = rb;
      oca = cb;
      ocb = ca;
      if (ra == rb) begin
         oca = step_coord(ca, dec_ff);
         ocb = step_coord(cb, dec_ff);
      end else if (ca == cb) begin
         ora = step_coord(ra, dec_ff);
         orb = step_coord(rb, dec_ff);
         oca = ca;
         ocb = cb;
      end
      oa = cell_index(ora, oca);
      ob = cell_index(orb, ocb);
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_rd) begin
         cell_a_ff <= cell_mem[oa];
         cell_b_ff <= cell_mem[ob];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (err_ff) begin
            rsp_ff <= '{result_first: 5'd0, result_second: 5'd0, status: 1'b1};
         end else begin
            rsp_ff <= '{result_first: cell_a_ff, result_second: cell_b_ff, status: 1'b0};
         end
      end
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.square_ready = ready_ff;
   assign sts.fin_last     = (fin_idx_ff == 5'(LETTERS - 1));
   assign sts.rsp_busy     = rsp_valid_ff & !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/playfair_digraph_cipher_top.sv =====
// Top level of the Playfair 5x5 digraph cipher: controller plus datapath.
// Clear and key transactions act on acceptance; finish, if the square is not yet ready, sweeps the
// alphabet one letter per cycle. A pair transaction steps through position read, cell read and
// result load, which waits while a result is pending; a pair before finish skips the cell read.
// The block accepts no new transaction until the current finish sweep or pair has completed.
// Synchronous active-high reset empties the square (only J marked used).
module playfair_digraph_cipher_top import pdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   pdc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   pdc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && !rsp_ready))
      else $error("result overwritten while pending");

   a_sweep_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_place |-> !req_ready)
      else $error("transaction accepted during finish sweep");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (rsp_data.result_first == 5'd0 && rsp_data.result_second == 5'd0))
      else $error("error result carries letters");

   a_ready_after_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_done |=> sts.square_ready)
      else $error("square not ready after finish");

endmodule
